// ----- rtl/fbre_pkg.sv -----
// ---------------------------------------------------------------------------
// fbre_pkg
// Shared types, codes and helpers of the frame buffer region engine.
// ---------------------------------------------------------------------------
package fbre_pkg;

   localparam int COORD_W = 11;
   localparam int POS_W = 13;
   localparam int DIM_W = 9;
   localparam int COLOR_W = 24;
   localparam int ADDR_W = 24;
   localparam int ACT_W = 3;
   localparam int STAT_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [ACT_W-1:0] ACT_WRITE = 3'd0;
   localparam logic [ACT_W-1:0] ACT_READ = 3'd1;
   localparam logic [ACT_W-1:0] ACT_REPLACE = 3'd2;
   localparam logic [ACT_W-1:0] ACT_MIRROR_X = 3'd3;
   localparam logic [ACT_W-1:0] ACT_MIRROR_Y = 3'd4;
   localparam logic [ACT_W-1:0] ACT_SPLIT = 3'd5;
   localparam logic [ACT_W-1:0] ACT_COPY = 3'd6;

   localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_REJECT = 2'd2;
   localparam logic [STAT_W-1:0] STAT_SKIP = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   typedef struct packed {
      logic en;
      logic we;
      logic [ADDR_W-1:0] addr;
      logic [COLOR_W-1:0] data;
   } mem_req_type;

   function automatic logic in_frame(input logic signed [POS_W-1:0] x,
                                     input logic signed [POS_W-1:0] y,
                                     input logic [DIM_W-1:0] w,
                                     input logic [DIM_W-1:0] h);
      return (x >= 13'sd0) && (x < $signed(POS_W'(w))) &&
             (y >= 13'sd0) && (y < $signed(POS_W'(h)));
   endfunction

   function automatic logic [ADDR_W-1:0] pix_addr(input logic signed [POS_W-1:0] x,
                                                  input logic signed [POS_W-1:0] y,
                                                  input logic [DIM_W-1:0] w,
                                                  input logic [DIM_W-1:0] h);
      logic [DIM_W-1:0] row;
      logic [2*DIM_W-1:0] prod;
      row = h - 9'd1 - y[DIM_W-1:0];
      prod = (2*DIM_W)'(row) * (2*DIM_W)'(w);
      return ADDR_W'(prod) + ADDR_W'(x[DIM_W-1:0]);
   endfunction

endpackage

// ----- rtl/frame_buffer_region_engine.sv -----
// ---------------------------------------------------------------------------
// frame_buffer_region_engine
// 24-bit frame buffer with pixel, replace, mirror, split and copy commands.
// ---------------------------------------------------------------------------
//  channel  dir   handshake          word
//  req_     in    valid / stall      one command
//  rsp_     out   valid / stall      pixel color and status
//  csr_     in    valid / ready      register index and value
//
//  Pixel commands touch one pixel; region commands walk the region pixel
//  by pixel via the single memory port: replace reads, writes on a match;
//  mirror reads a pair, swaps it; copy reads source, writes target; split
//  divides the spacing, then fills lines. One command is in work at a time.
//  Reset is synchronous; the pixel memory is not cleared.
//  A result waits in the output register while the next command is taken.
// ---------------------------------------------------------------------------
module frame_buffer_region_engine #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [fbre_pkg::ACT_W-1:0]     req_action,
   input  logic signed [10:0]             req_x_first,
   input  logic signed [10:0]             req_y_first,
   input  logic signed [10:0]             req_x_second,
   input  logic signed [10:0]             req_y_second,
   input  logic signed [10:0]             req_x_target,
   input  logic signed [10:0]             req_y_target,
   input  logic [fbre_pkg::COLOR_W-1:0]   req_color_main,
   input  logic [fbre_pkg::COLOR_W-1:0]   req_color_match,
   input  logic [fbre_pkg::DIM_W-1:0]     req_count_across,
   input  logic [fbre_pkg::DIM_W-1:0]     req_count_down,
   input  logic [fbre_pkg::DIM_W-1:0]     req_line_thickness,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fbre_pkg::COLOR_W-1:0]   rsp_pixel_color,
   output logic [fbre_pkg::STAT_W-1:0]    rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fbre_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fbre_pkg::DIM_W-1:0]     csr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RST_W = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
   localparam int RST_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
   localparam int PW = fbre_pkg::POS_W;
   localparam int DW = fbre_pkg::DIM_W;
   localparam int CLW = fbre_pkg::COLOR_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD_A = 4'd1;
   localparam logic [3:0] S_RD_B = 4'd2;
   localparam logic [3:0] S_WR_A = 4'd3;
   localparam logic [3:0] S_WR_B = 4'd4;
   localparam logic [3:0] S_CAP = 4'd5;
   localparam logic [3:0] S_DIV = 4'd6;
   localparam logic [3:0] S_SPL = 4'd7;
   localparam logic [3:0] S_FILL = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [fbre_pkg::ACT_W-1:0] cmd_ff, cmd_in;
   logic [CLW-1:0] main_ff, main_in, match_ff, match_in;
   logic [DW-1:0] nx_ff, nx_in, ny_ff, ny_in, th_ff, th_in;
   logic [DW-1:0] w_ff, w_in, h_ff, h_in;
   logic signed [PW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [PW-1:0] xlo_ff, xlo_in, ylo_ff, ylo_in;
   logic signed [PW-1:0] xlim_ff, xlim_in, ylim_ff, ylim_in;
   logic signed [PW-1:0] kx_ff, kx_in, ky_ff, ky_in;
   logic negx_ff, negx_in, negy_ff, negy_in, colmaj_ff, colmaj_in;
   logic [CLW-1:0] t_ff, t_in, pix_ff, pix_in;
   logic flag_ff, flag_in;
   logic [fbre_pkg::STAT_W-1:0] code_ff, code_in;
   logic [2*DW-1:0] lastx_ff, lastx_in, lasty_ff, lasty_in;
   logic [DW-1:0] xi_ff, xi_in, yi_ff, yi_in;
   logic [DW:0] xs_ff, xs_in, xe_ff, xe_in, ys_ff, ys_in, ye_ff, ye_in;
   logic xv_ff, xv_in, yv_ff, yv_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CLW-1:0] rsp_pix_ff, rsp_pix_in;
   logic [fbre_pkg::STAT_W-1:0] rsp_st_ff, rsp_st_in;

   fbre_pkg::mem_req_type mem_req;
   logic [CLW-1:0] rd_q;
   logic div_start, busy_x, busy_y;
   logic [DW-1:0] qx, qy;

   logic accept;
   logic signed [PW-1:0] x1, y1, x2, y2, xt, yt, dxr, dyr, dw, dh, wext, hext;
   logic signed [PW-1:0] bx, by;
   logic a_in, b_in;
   logic [CLW-1:0] a_val;
   logic x_last, y_last, step_done, row_wrap;
   logic signed [PW-1:0] step_cx, step_cy;
   logic hit_x, hit_y, cov_x, cov_y;
   logic split_ok;

   fbre_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock(clock),
      .mem_req(mem_req),
      .rd_q(rd_q)
   );

   fbre_div u_div_x (
      .clock(clock), .reset(reset), .start(div_start),
      .num(w_ff), .den(req_count_across), .busy(busy_x), .quo(qx)
   );

   fbre_div u_div_y (
      .clock(clock), .reset(reset), .start(div_start),
      .num(h_ff), .den(req_count_down), .busy(busy_y), .quo(qy)
   );

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign x1 = PW'(req_x_first);
   assign y1 = PW'(req_y_first);
   assign x2 = PW'(req_x_second);
   assign y2 = PW'(req_y_second);
   assign xt = PW'(req_x_target);
   assign yt = PW'(req_y_target);
   assign dxr = x2 - x1;
   assign dyr = y2 - y1;
   assign wext = $signed(PW'(w_ff));
   assign hext = $signed(PW'(h_ff));
   assign dw = wext - xt;
   assign dh = hext - yt;
   assign split_ok = (req_count_across != '0) && (req_count_across <= w_ff) &&
                     (req_count_down != '0) && (req_count_down <= h_ff) &&
                     (req_line_thickness != '0) && (req_line_thickness <= w_ff);
   assign div_start = accept && (req_action == fbre_pkg::ACT_SPLIT) && split_ok;

   assign bx = negx_ff ? kx_ff - cx_ff : kx_ff + cx_ff;
   assign by = negy_ff ? ky_ff - cy_ff : ky_ff + cy_ff;
   assign a_in = fbre_pkg::in_frame(cx_ff, cy_ff, w_ff, h_ff);
   assign b_in = fbre_pkg::in_frame(bx, by, w_ff, h_ff);
   assign a_val = a_in ? rd_q : '0;

   assign x_last = (cx_ff + 13'sd1) >= xlim_ff;
   assign y_last = (cy_ff + 13'sd1) >= ylim_ff;
   assign step_done = x_last && y_last;
   assign row_wrap = colmaj_ff ? y_last : x_last;

   always_comb begin
      if (colmaj_ff) begin
         step_cy = y_last ? ylo_ff : cy_ff + 13'sd1;
         step_cx = y_last ? cx_ff + 13'sd1 : cx_ff;
      end else begin
         step_cx = x_last ? xlo_ff : cx_ff + 13'sd1;
         step_cy = x_last ? cy_ff + 13'sd1 : cy_ff;
      end
   end

   assign hit_x = (cx_ff[DW:0] == xs_ff) && (xi_ff < nx_ff);
   assign hit_y = (cy_ff[DW:0] == ys_ff) && (yi_ff < ny_ff);
   assign cov_x = hit_x || (xv_ff && (cx_ff[DW:0] <= xe_ff));
   assign cov_y = hit_y || (yv_ff && (cy_ff[DW:0] <= ye_ff));

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      main_in = main_ff;
      match_in = match_ff;
      nx_in = nx_ff;
      ny_in = ny_ff;
      th_in = th_ff;
      w_in = w_ff;
      h_in = h_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      xlo_in = xlo_ff;
      ylo_in = ylo_ff;
      xlim_in = xlim_ff;
      ylim_in = ylim_ff;
      kx_in = kx_ff;
      ky_in = ky_ff;
      negx_in = negx_ff;
      negy_in = negy_ff;
      colmaj_in = colmaj_ff;
      t_in = t_ff;
      pix_in = pix_ff;
      flag_in = flag_ff;
      code_in = code_ff;
      lastx_in = lastx_ff;
      lasty_in = lasty_ff;
      xi_in = xi_ff;
      xs_in = xs_ff;
      xe_in = xe_ff;
      xv_in = xv_ff;
      yi_in = yi_ff;
      ys_in = ys_ff;
      ye_in = ye_ff;
      yv_in = yv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pix_in = rsp_pix_ff;
      rsp_st_in = rsp_st_ff;
      mem_req = '0;

      if (csr_valid && csr_ready) begin
         if (csr_index == fbre_pkg::REG_IMAGE_WIDTH) begin
            if (csr_data == '0) begin
               w_in = DW'(1);
            end else if (32'(csr_data) > MAX_WIDTH) begin
               w_in = DW'(MAX_WIDTH);
            end else begin
               w_in = csr_data;
            end
         end else if (csr_index == fbre_pkg::REG_IMAGE_HEIGHT) begin
            if (csr_data == '0) begin
               h_in = DW'(1);
            end else if (32'(csr_data) > MAX_HEIGHT) begin
               h_in = DW'(MAX_HEIGHT);
            end else begin
               h_in = csr_data;
            end
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_action;
               main_in = req_color_main;
               match_in = req_color_match;
               nx_in = req_count_across;
               ny_in = req_count_down;
               th_in = req_line_thickness;
               pix_in = '0;
               flag_in = 1'b0;
               code_in = fbre_pkg::STAT_OK;
               cx_in = x1;
               cy_in = y1;
               xlo_in = x1;
               ylo_in = y1;
               xlim_in = x2;
               ylim_in = y2;
               kx_in = '0;
               ky_in = '0;
               negx_in = 1'b0;
               negy_in = 1'b0;
               colmaj_in = 1'b0;
               state_in = S_DONE;
               unique case (req_action)
                  fbre_pkg::ACT_WRITE: state_in = S_WR_A;
                  fbre_pkg::ACT_READ: state_in = S_RD_A;
                  fbre_pkg::ACT_REPLACE, fbre_pkg::ACT_SPLIT: begin
                     cx_in = '0;
                     cy_in = '0;
                     xlo_in = '0;
                     ylo_in = '0;
                     xlim_in = wext;
                     ylim_in = hext;
                     if (req_action == fbre_pkg::ACT_REPLACE) begin
                        state_in = S_RD_A;
                     end else if (split_ok) begin
                        state_in = S_DIV;
                     end else begin
                        code_in = fbre_pkg::STAT_REJECT;
                     end
                  end
                  fbre_pkg::ACT_MIRROR_X: begin
                     xlim_in = x1 + (dxr >>> 1);
                     kx_in = x1 + x2 - 13'sd1;
                     negx_in = 1'b1;
                     if (dxr >= 13'sd2 && dyr > 13'sd0) begin
                        state_in = S_RD_A;
                     end
                  end
                  fbre_pkg::ACT_MIRROR_Y: begin
                     ylim_in = y1 + (dyr >>> 1);
                     ky_in = y1 + y2 - 13'sd1;
                     negy_in = 1'b1;
                     if (dyr >= 13'sd2 && dxr > 13'sd0) begin
                        state_in = S_RD_A;
                     end
                  end
                  fbre_pkg::ACT_COPY: begin
                     colmaj_in = 1'b1;
                     kx_in = xt - x1;
                     ky_in = yt - y1;
                     if (x1 < 13'sd0 || y1 < 13'sd0 || xt < 13'sd0 || yt < 13'sd0 ||
                         dxr <= 13'sd0 || dyr <= 13'sd0 || dw <= 13'sd0 ||
                         dh <= 13'sd0) begin
                        code_in = fbre_pkg::STAT_REJECT;
                     end else if (dxr > dw || dyr > dh) begin
                        code_in = fbre_pkg::STAT_SKIP;
                     end else begin
                        state_in = S_RD_A;
                     end
                  end
                  default: code_in = fbre_pkg::STAT_REJECT;
               endcase
            end
         end
         S_RD_A: begin
            if (a_in) begin
               mem_req.en = 1'b1;
               mem_req.addr = fbre_pkg::pix_addr(cx_ff, cy_ff, w_ff, h_ff);
            end else begin
               flag_in = 1'b1;
            end
            unique case (cmd_ff)
               fbre_pkg::ACT_READ: state_in = S_CAP;
               fbre_pkg::ACT_REPLACE: state_in = S_WR_A;
               fbre_pkg::ACT_COPY: state_in = S_WR_B;
               default: state_in = S_RD_B;
            endcase
         end
         S_CAP: begin
            pix_in = a_val;
            state_in = S_DONE;
         end
         S_RD_B: begin
            t_in = a_val;
            if (b_in) begin
               mem_req.en = 1'b1;
               mem_req.addr = fbre_pkg::pix_addr(bx, by, w_ff, h_ff);
            end else begin
               flag_in = 1'b1;
            end
            state_in = S_WR_A;
         end
         S_WR_A: begin
            mem_req.addr = fbre_pkg::pix_addr(cx_ff, cy_ff, w_ff, h_ff);
            mem_req.data = main_ff;
            unique case (cmd_ff)
               fbre_pkg::ACT_REPLACE: begin
                  mem_req.en = (rd_q == match_ff);
                  mem_req.we = 1'b1;
                  state_in = step_done ? S_DONE : S_RD_A;
                  cx_in = step_cx;
                  cy_in = step_cy;
               end
               fbre_pkg::ACT_WRITE: begin
                  mem_req.en = a_in;
                  mem_req.we = 1'b1;
                  flag_in = flag_ff || !a_in;
                  state_in = S_DONE;
               end
               default: begin
                  mem_req.en = a_in;
                  mem_req.we = 1'b1;
                  mem_req.data = b_in ? rd_q : '0;
                  flag_in = flag_ff || !a_in;
                  state_in = S_WR_B;
               end
            endcase
         end
         S_WR_B: begin
            mem_req.en = b_in;
            mem_req.we = 1'b1;
            mem_req.addr = fbre_pkg::pix_addr(bx, by, w_ff, h_ff);
            mem_req.data = (cmd_ff == fbre_pkg::ACT_COPY) ? a_val : t_ff;
            flag_in = flag_ff || !b_in;
            state_in = step_done ? S_DONE : S_RD_A;
            cx_in = step_cx;
            cy_in = step_cy;
         end
         S_DIV: begin
            if (!busy_x && !busy_y) begin
               lastx_in = (2*DW)'(nx_ff - 1'b1) * (2*DW)'(qx);
               lasty_in = (2*DW)'(ny_ff - 1'b1) * (2*DW)'(qy);
               state_in = S_SPL;
            end
         end
         S_SPL: begin
            if ((nx_ff > DW'(1) && (lastx_ff + (2*DW)'(th_ff)) > (2*DW)'(w_ff)) ||
                (ny_ff > DW'(1) && (lasty_ff + (2*DW)'(th_ff)) > (2*DW)'(h_ff))) begin
               flag_in = 1'b1;
            end
            xi_in = DW'(1);
            xs_in = (DW+1)'(qx);
            xv_in = 1'b0;
            yi_in = DW'(1);
            ys_in = (DW+1)'(qy);
            yv_in = 1'b0;
            state_in = S_FILL;
         end
         S_FILL: begin
            mem_req.en = cov_x || cov_y;
            mem_req.we = 1'b1;
            mem_req.addr = fbre_pkg::pix_addr(cx_ff, cy_ff, w_ff, h_ff);
            mem_req.data = main_ff;
            if (row_wrap) begin
               xi_in = DW'(1);
               xs_in = (DW+1)'(qx);
               xv_in = 1'b0;
               if (hit_y) begin
                  yi_in = yi_ff + 1'b1;
                  ys_in = ys_ff + (DW+1)'(qy);
                  ye_in = cy_ff[DW:0] + (DW+1)'(th_ff) - 1'b1;
                  yv_in = 1'b1;
               end
            end else if (hit_x) begin
               xi_in = xi_ff + 1'b1;
               xs_in = xs_ff + (DW+1)'(qx);
               xe_in = cx_ff[DW:0] + (DW+1)'(th_ff) - 1'b1;
               xv_in = 1'b1;
            end
            cx_in = step_cx;
            cy_in = step_cy;
            if (step_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in = pix_ff;
               if (code_ff != fbre_pkg::STAT_OK) begin
                  rsp_st_in = code_ff;
               end else begin
                  rsp_st_in = flag_ff ? fbre_pkg::STAT_OUTSIDE : fbre_pkg::STAT_OK;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         w_ff <= DW'(RST_W);
         h_ff <= DW'(RST_H);
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         w_ff <= w_in;
         h_ff <= h_in;
      end
      cmd_ff <= cmd_in;
      main_ff <= main_in;
      match_ff <= match_in;
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      th_ff <= th_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      xlo_ff <= xlo_in;
      ylo_ff <= ylo_in;
      xlim_ff <= xlim_in;
      ylim_ff <= ylim_in;
      kx_ff <= kx_in;
      ky_ff <= ky_in;
      negx_ff <= negx_in;
      negy_ff <= negy_in;
      colmaj_ff <= colmaj_in;
      t_ff <= t_in;
      pix_ff <= pix_in;
      flag_ff <= flag_in;
      code_ff <= code_in;
      lastx_ff <= lastx_in;
      lasty_ff <= lasty_in;
      xi_ff <= xi_in;
      xs_ff <= xs_in;
      xe_ff <= xe_in;
      xv_ff <= xv_in;
      yi_ff <= yi_in;
      ys_ff <= ys_in;
      ye_ff <= ye_in;
      yv_ff <= yv_in;
      rsp_pix_ff <= rsp_pix_in;
      rsp_st_ff <= rsp_st_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_color = rsp_pix_ff;
   assign rsp_status = rsp_st_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("command accepted but engine stayed idle");

   a_mem_only_busy: assert property (@(posedge clock) disable iff (reset)
      mem_req.en |-> (state_ff == S_RD_A || state_ff == S_RD_B || state_ff == S_WR_A ||
                      state_ff == S_WR_B || state_ff == S_FILL))
      else $error("memory access outside a pixel step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside the done step");

   a_div_in_split: assert property (@(posedge clock) disable iff (reset)
      (busy_x || busy_y) |-> state_ff == S_DIV)
      else $error("divider busy outside the split setup");

endmodule

// ----- rtl/fbre_store.sv -----
// ---------------------------------------------------------------------------
// fbre_store
// Pixel memory: one port, synchronous read into a registered output.
// ---------------------------------------------------------------------------
module fbre_store #(
   parameter int DEPTH = 65536,
   parameter int AW = 16
) (
   input  logic                          clock,
   input  fbre_pkg::mem_req_type         mem_req,
   output logic [fbre_pkg::COLOR_W-1:0]  rd_q
);

   logic [fbre_pkg::COLOR_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.en && mem_req.we) begin
         mem[mem_req.addr[AW-1:0]] <= mem_req.data;
      end
      if (mem_req.en && !mem_req.we) begin
         rd_q <= mem[mem_req.addr[AW-1:0]];
      end
   end

endmodule

// ----- rtl/fbre_div.sv -----
// ---------------------------------------------------------------------------
// fbre_div
// Restoring divider, one quotient bit per cycle, for the split spacing.
// ---------------------------------------------------------------------------
module fbre_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fbre_pkg::DIM_W-1:0]  num,
   input  logic [fbre_pkg::DIM_W-1:0]  den,
   output logic                        busy,
   output logic [fbre_pkg::DIM_W-1:0]  quo
);

   localparam int CW = $clog2(fbre_pkg::DIM_W + 1);

   logic busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [fbre_pkg::DIM_W:0] rem_ff, rem_in;
   logic [fbre_pkg::DIM_W-1:0] quo_ff, quo_in;
   logic [fbre_pkg::DIM_W-1:0] den_ff, den_in;
   logic [fbre_pkg::DIM_W:0] shifted;
   logic ge;

   always_comb begin
      shifted = {rem_ff[fbre_pkg::DIM_W-1:0], quo_ff[fbre_pkg::DIM_W-1]};
      ge = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CW'(fbre_pkg::DIM_W);
         rem_in = '0;
         quo_in = num;
         den_in = den;
      end else if (busy_ff) begin
         rem_in = ge ? shifted - {1'b0, den_ff} : shifted;
         quo_in = {quo_ff[fbre_pkg::DIM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo = quo_ff;

endmodule
